[hdl/ascii_coordinate_frame_parser_macros.svh]
// Assertion macros shared by the coordinate frame parser modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASCII_COORDINATE_FRAME_PARSER_MACROS_SVH
`define ASCII_COORDINATE_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define ACFP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// When the trigger holds, the consequence must hold in the following cycle.
`define ACFP_ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define ACFP_ASSERT(label, clk, rst, prop, msg)
`define ACFP_ASSERT_NEXT(label, clk, rst, trig, cons, msg)
`endif

`endif

[hdl/acfp_pkg.sv]
`timescale 1ns / 1ps

package acfp_pkg;

  // Frame length guard: a byte that arrives with this many minus one bytes
  // already in the frame is dropped and the parser starts over.
  localparam int FRAME_LIMIT = 32;
  localparam int CNT_W = 8;
  localparam logic [CNT_W-1:0] FRAME_LAST = CNT_W'(FRAME_LIMIT - 1);

  // Largest field magnitude that is kept; anything above saturates here.
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Frame characters.
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Parser phase.
  typedef enum logic [5:0] {
    PH_AT   = 6'b000001,
    PH_OPEN = 6'b000010,
    PH_X    = 6'b000100,
    PH_Y    = 6'b001000,
    PH_CR   = 6'b010000,
    PH_LF   = 6'b100000
  } phase_t;

  // Progress through the optional minus sign and digits of a field.
  typedef enum logic [3:0] {
    PF_START  = 4'b0001,
    PF_MINUS  = 4'b0010,
    PF_DIGITS = 4'b0100,
    PF_ENDED  = 4'b1000
  } prefix_t;

  // Per-word status codes.
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_X_BAD    = 2'd2,
    ST_Y_BAD    = 2'd3
  } status_t;

  // Field accumulator.
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
    prefix_t     pf;
  } field_t;

  // One result word.
  typedef struct packed {
    status_t            status;
    logic               frame_done;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } result_t;

endpackage

[hdl/acfp_field.sv]
`timescale 1ns / 1ps

module acfp_field import acfp_pkg::*; (
  input  field_t      cur,
  input  logic [7:0]  ch,
  input  logic        feed,
  input  logic        clear,
  output field_t      nxt,
  output logic [31:0] value,
  output logic        malformed
);

  logic [35:0] prod;

  // Magnitude times ten plus the new digit, wide enough not to wrap.
  assign prod = ({4'd0, cur.mag} << 3) + ({4'd0, cur.mag} << 1) + {32'd0, ch[3:0]};

  // Next accumulator state for a clear, a digit or a minus sign.
  always_comb begin
    nxt = cur;
    if (clear) begin
      nxt.mag = '0;
      nxt.neg = 1'b0;
      nxt.pf  = PF_START;
    end else if (feed) begin
      if (ch == CH_MINUS) begin
        unique case (cur.pf)
          PF_START: begin
            nxt.neg = 1'b1;
            nxt.pf  = PF_MINUS;
          end
          PF_MINUS: begin
            // A second sign ends the prefix with nothing usable.
            nxt.neg = 1'b0;
            nxt.mag = '0;
            nxt.pf  = PF_ENDED;
          end
          default: begin
            nxt.pf = PF_ENDED;
          end
        endcase
      end else if (cur.pf != PF_ENDED) begin
        nxt.mag = (prod > {4'd0, MAG_CAP}) ? MAG_CAP : prod[31:0];
        nxt.pf  = PF_DIGITS;
      end
    end
  end

  // Two's complement value of the prefix, clamped to the signed range.
  always_comb begin
    unique case (cur.pf) inside
      PF_START, PF_MINUS: value = '0;
      default: begin
        if (cur.neg) begin
          value = 32'd0 - cur.mag;
        end else begin
          value = (cur.mag > POS_MAX) ? POS_MAX : cur.mag;
        end
      end
    endcase
  end

  assign malformed = (cur.pf == PF_MINUS) || (cur.pf == PF_ENDED);

endmodule

[hdl/acfp_parser.sv]
`timescale 1ns / 1ps
`include "ascii_coordinate_frame_parser_macros.svh"

module acfp_parser import acfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  output result_t    result
);

  phase_t             phase, phase_next;
  logic [CNT_W-1:0]   frame_count, frame_count_next;
  field_t             fld, fld_next;
  logic signed [31:0] held_x, held_x_next;
  logic signed [31:0] held_y, held_y_next;

  logic        is_digit;
  logic        fld_feed;
  logic        fld_clear;
  logic [31:0] fld_value;
  logic        fld_bad;
  status_t     status;
  logic        done;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  acfp_field u_field (
    .cur       (fld),
    .ch        (rx_byte),
    .feed      (fld_feed),
    .clear     (fld_clear),
    .nxt       (fld_next),
    .value     (fld_value),
    .malformed (fld_bad)
  );

  // Phase decision for the word at hand.
  always_comb begin
    phase_next       = phase;
    frame_count_next = frame_count;
    held_x_next      = held_x;
    held_y_next      = held_y;
    fld_feed         = 1'b0;
    fld_clear        = 1'b0;
    status           = ST_NONE;
    done             = 1'b0;

    if (frame_count >= FRAME_LAST) begin
      // Frame too long: drop this byte and start over.
      phase_next       = PH_AT;
      frame_count_next = '0;
      status           = ST_OVERFLOW;
    end else begin
      unique case (phase)
        PH_OPEN: begin
          frame_count_next = frame_count + 1'b1;
          if (rx_byte == CH_OPEN) begin
            fld_clear  = 1'b1;
            phase_next = PH_X;
          end else begin
            phase_next = PH_AT;
          end
        end
        PH_X: begin
          frame_count_next = frame_count + 1'b1;
          if (rx_byte == CH_COMMA) begin
            held_x_next = fld_value;
            if (fld_bad) begin
              status     = ST_X_BAD;
              phase_next = PH_AT;
            end else begin
              fld_clear  = 1'b1;
              phase_next = PH_Y;
            end
          end else if (is_digit || rx_byte == CH_MINUS) begin
            fld_feed = 1'b1;
          end else begin
            phase_next = PH_AT;
          end
        end
        PH_Y: begin
          frame_count_next = frame_count + 1'b1;
          if (rx_byte == CH_CLOSE) begin
            held_y_next = fld_value;
            if (fld_bad) begin
              status = ST_Y_BAD;
            end
            phase_next = PH_CR;
          end else if (is_digit || rx_byte == CH_MINUS) begin
            fld_feed = 1'b1;
          end else begin
            phase_next = PH_AT;
          end
        end
        PH_CR: begin
          frame_count_next = frame_count + 1'b1;
          phase_next = (rx_byte == CH_CR) ? PH_LF : PH_AT;
        end
        PH_LF: begin
          done       = (rx_byte == CH_LF);
          phase_next = PH_AT;
        end
        default: begin
          phase_next = PH_AT;
          if (rx_byte == CH_AT) begin
            frame_count_next = CNT_W'(1);
            phase_next       = PH_OPEN;
          end
        end
      endcase
      if (phase_next == PH_AT) begin
        frame_count_next = '0;
      end
    end
  end

  // Parser state advances once per word taken from the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_AT;
      frame_count <= '0;
      fld         <= '{mag: '0, neg: 1'b0, pf: PF_START};
      held_x      <= '0;
      held_y      <= '0;
    end else if (step_en) begin
      phase       <= phase_next;
      frame_count <= frame_count_next;
      fld         <= fld_next;
      held_x      <= held_x_next;
      held_y      <= held_y_next;
    end
  end

  assign result = '{status: status, frame_done: done,
                    x_value: held_x_next, y_value: held_y_next};

  `ACFP_ASSERT(a_idle_count_zero, clk, rst, (phase != PH_AT) || (frame_count == '0), "count not clear while waiting for a frame")
  `ACFP_ASSERT(a_count_bound, clk, rst, frame_count <= FRAME_LAST, "frame count passed the length limit")
  `ACFP_ASSERT_NEXT(a_done_returns, clk, rst, step_en && done, phase == PH_AT, "parser did not return to idle after a frame")

endmodule

[hdl/ascii_coordinate_frame_parser.sv]
`timescale 1ns / 1ps
// Channel   Dir  Signals                      Contents
// s_        in   tvalid tready tdata[7:0]     received byte
// m_        out  tvalid tready tdata[63:0]    x_value, y_value
//                tlast tuser[1:0]             frame_done, status
//
// One result word for every input byte, one byte per cycle sustained while m_tready stays high.
// Each byte passes through the byte register, then the parse step into the result register.
// The parse state and field accumulator update in the cycle a byte moves
// from the byte register into the result register.
// rst is synchronous; it returns the parser to waiting for '@' with x and y at zero.
// While the result register is stalled, one more byte is held in the byte register.
`include "ascii_coordinate_frame_parser_macros.svh"

module ascii_coordinate_frame_parser import acfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] x_value, [63:32] y_value
  output logic        m_tlast,   // frame_done
  output logic [1:0]  m_tuser    // [1:0] status
);

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       step;
  result_t    result;
  result_t    res_q;

  // Byte register moves on whenever the result register can take a word.
  assign advance  = !m_tvalid || m_tready;
  assign step     = in_full && advance;
  assign s_tready = !in_full || advance;

  // Input byte register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  acfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step_en (step),
    .rx_byte (in_byte),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= result;
    end
  end

  assign m_tdata = {res_q.y_value, res_q.x_value};
  assign m_tlast = res_q.frame_done;
  assign m_tuser = res_q.status;

  `ACFP_ASSERT(a_stall_blocks_input, clk, rst, !(in_full && m_tvalid && !m_tready) || !s_tready, "input taken while both registers are full")
  `ACFP_ASSERT_NEXT(a_held_byte_kept, clk, rst, in_full && !advance, in_full, "held byte lost during a stall")
  `ACFP_ASSERT_NEXT(a_result_from_byte, clk, rst, !in_full && !(m_tvalid && !m_tready), !m_tvalid, "result word appeared with no byte behind it")

endmodule

[sim/ascii_coordinate_frame_parser_test.sv]
`timescale 1ns / 1ps

module ascii_coordinate_frame_parser_test import acfp_pkg::*;;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 1630;
  localparam int QUIET_BYTES   = 300;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] rx_byte
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;    // [31:0] x_value, [63:32] y_value
  logic        m_tlast;    // frame_done
  logic [1:0]  m_tuser;    // [1:0] status

  ascii_coordinate_frame_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // Shadow copy of the parser state.
  phase_t             phase;
  prefix_t            prefix;
  logic [CNT_W-1:0]   frame_bytes;
  logic [31:0]        magnitude;
  logic               negative;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  result_t predicted_words[$];
  int      error_count;
  int      bytes_sent;
  int      cycle_count;
  bit      idle_on;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void clear_field();
    magnitude = '0;
    negative  = 1'b0;
    prefix    = PF_START;
  endfunction

  // Track the leading '-'?digits prefix of a field.
  function automatic void feed_field(input logic [7:0] c);
    logic [63:0] grown;
    if (c == CH_MINUS) begin
      if (prefix == PF_START) begin
        negative = 1'b1;
        prefix   = PF_MINUS;
      end else if (prefix == PF_MINUS) begin
        negative  = 1'b0;
        magnitude = '0;
        prefix    = PF_ENDED;
      end else begin
        prefix = PF_ENDED;
      end
    end else if (prefix != PF_ENDED) begin
      grown     = {32'd0, magnitude} * 64'd10 + 64'(c - CH_ZERO);
      magnitude = (grown > {32'd0, MAG_CAP}) ? MAG_CAP : grown[31:0];
      prefix    = PF_DIGITS;
    end
  endfunction

  function automatic logic [31:0] field_value();
    if (prefix == PF_START || prefix == PF_MINUS) return '0;
    if (negative) return -magnitude;
    return (magnitude > POS_MAX) ? POS_MAX : magnitude;
  endfunction

  function automatic bit field_bad();
    return prefix == PF_MINUS || prefix == PF_ENDED;
  endfunction

  // Advance the shadow parser by one byte and return the word it produces.
  function automatic result_t parse_rx_byte(input logic [7:0] c);
    result_t word;
    bit      is_digit;
    word.status     = ST_NONE;
    word.frame_done = 1'b0;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (frame_bytes >= FRAME_LAST) begin
      phase       = PH_AT;
      frame_bytes = '0;
      word.status = ST_OVERFLOW;
    end else begin
      case (phase)
        PH_OPEN: begin
          frame_bytes++;
          if (c == CH_OPEN) begin
            clear_field();
            phase = PH_X;
          end else begin
            phase = PH_AT;
          end
        end
        PH_X: begin
          frame_bytes++;
          if (c == CH_COMMA) begin
            coord_x = field_value();
            if (field_bad()) begin
              word.status = ST_X_BAD;
              phase       = PH_AT;
            end else begin
              clear_field();
              phase = PH_Y;
            end
          end else if (is_digit || c == CH_MINUS) begin
            feed_field(c);
          end else begin
            phase = PH_AT;
          end
        end
        PH_Y: begin
          frame_bytes++;
          if (c == CH_CLOSE) begin
            coord_y = field_value();
            if (field_bad()) word.status = ST_Y_BAD;
            phase = PH_CR;
          end else if (is_digit || c == CH_MINUS) begin
            feed_field(c);
          end else begin
            phase = PH_AT;
          end
        end
        PH_CR: begin
          frame_bytes++;
          phase = (c == CH_CR) ? PH_LF : PH_AT;
        end
        PH_LF: begin
          if (c == CH_LF) word.frame_done = 1'b1;
          phase = PH_AT;
        end
        default: begin
          phase = PH_AT;
          if (c == CH_AT) begin
            frame_bytes = CNT_W'(1);
            phase       = PH_OPEN;
          end
        end
      endcase
      if (phase == PH_AT) frame_bytes = '0;
    end
    word.x_value = coord_x;
    word.y_value = coord_y;
    return word;
  endfunction

  // Present one byte, wait for the handshake, then maybe leave a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predicted_words.push_back(parse_rx_byte(b));
    bytes_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // A frame body followed by CR LF.
  task automatic send_frame(input string body);
    send_text(body);
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic wait_for_results();
    while (predicted_words.size() != 0) @(posedge clk);
  endtask

  function automatic string digit_string(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  // Random field text: mostly well formed, sometimes empty, long or malformed.
  function automatic string random_field();
    string s;
    int    kind;
    kind = $urandom_range(0, 19);
    if (kind == 0) return "";
    if (kind == 1) return "-";
    if (kind == 2) return {"--", digit_string($urandom_range(0, 3))};
    if (kind == 3) return {digit_string($urandom_range(1, 3)), "-", digit_string($urandom_range(0, 3))};
    if (kind == 4) return {"-", digit_string($urandom_range(9, 14))};
    if (kind == 5) return digit_string($urandom_range(9, 14));
    s = ($urandom_range(0, 1) != 0) ? "-" : "";
    return {s, digit_string($urandom_range(1, 6))};
  endfunction

  // Replace a frame byte by a random one now and then.
  function automatic logic [7:0] mangle(input logic [7:0] b);
    if ($urandom_range(0, 24) == 0) return 8'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic test_plain_frames();
    send_frame("@(12,-34)");
    send_frame("@(0,7)");
    send_frame("@(,)");
    send_frame("@(-5,)");
  endtask

  task automatic test_extreme_values();
    send_frame("@(2147483647,-2147483648)");
    send_frame("@(2147483648,-2147483649)");
    send_frame("@(99999999999999,-00000000000001)");
  endtask

  task automatic test_malformed_fields();
    send_frame("@(-,5)");
    send_frame("@(--7,1)");
    send_frame("@(1-2,3)");
    send_frame("@(4,--)");
    send_frame("@(5,6-9)");
    send_frame("@(8,-)");
  endtask

  task automatic test_broken_frames();
    send_text("zz@x@(1a");
    send_frame("@(1,2)X");
    send_text("@(3,4)");
    send_byte(CH_CR);
    send_byte(CH_AT);
    send_text("@(5,6)");
    send_byte(CH_LF);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // Frames that end just inside and just past the length guard, and a runaway field.
  task automatic test_length_limit();
    send_frame({"@(", digit_string(12), ",", digit_string(FRAME_LIMIT - 19), ")"});
    send_frame({"@(", digit_string(12), ",", digit_string(FRAME_LIMIT - 18), ")"});
    send_text({"@(", digit_string(FRAME_LIMIT + 2)});
    send_frame("@(9,9)");
  endtask

  task automatic test_random_traffic();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start >= RANDOM_BYTES - QUIET_BYTES) idle_on = 1'b0;
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
      send_byte(mangle(CH_AT));
      send_byte(mangle(CH_OPEN));
      if ($urandom_range(0, 19) == 0) begin
        send_text(digit_string($urandom_range(FRAME_LIMIT - 8, FRAME_LIMIT + 3)));
      end else begin
        send_text(random_field());
      end
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom_range(0, 255)));
      send_byte(mangle(CH_COMMA));
      send_text(random_field());
      if ($urandom_range(0, 24) == 0) send_byte(8'($urandom_range(0, 255)));
      send_byte(mangle(CH_CLOSE));
      send_byte(mangle(CH_CR));
      send_byte(mangle(CH_LF));
    end
  endtask

  // Result side: random back-pressure bursts until the quiet tail.
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Compare each result word with the oldest prediction.
  always @(posedge clk) begin : check_words
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_words.size() == 0) begin
        $error("unexpected result word");
        error_count++;
      end else begin
        want = predicted_words.pop_front();
        if (m_tuser != want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tuser);
          error_count++;
        end
        if (m_tlast != want.frame_done) begin
          $error("frame_done: expected %0d, got %0d", want.frame_done, m_tlast);
          error_count++;
        end
        if ($signed(m_tdata[31:0]) != want.x_value) begin
          $error("x_value: expected %0d, got %0d", want.x_value, $signed(m_tdata[31:0]));
          error_count++;
        end
        if ($signed(m_tdata[63:32]) != want.y_value) begin
          $error("y_value: expected %0d, got %0d", want.y_value, $signed(m_tdata[63:32]));
          error_count++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    error_count = 0;
    bytes_sent  = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    phase       = PH_AT;
    frame_bytes = '0;
    coord_x     = '0;
    coord_y     = '0;
    clear_field();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_plain_frames();
    test_extreme_values();
    test_malformed_fields();
    test_broken_frames();
    test_length_limit();

    // Hold the sender until the result side has caught up.
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_for_results();

    test_random_traffic();

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/acfp_pkg.sv
hdl/acfp_field.sv
hdl/acfp_parser.sv
hdl/ascii_coordinate_frame_parser.sv
sim/ascii_coordinate_frame_parser_test.sv
